// ===== rtl/swm_pkg.sv =====
// shared constants, types and control struct for the sliding window median filter
// no dependencies; imported by swm_lane, swm_merge, sliding_window_median_xyz and tb
package swm_pkg;

	localparam int MAX_WINDOW  = 16;
	localparam int SAMPLE_BITS = 32;
	localparam int IDX_W       = $clog2(MAX_WINDOW);
	localparam int CNT_W       = $clog2(MAX_WINDOW + 1);
	localparam int LEN_W       = 5;
	localparam int IN_W        = ((3 * SAMPLE_BITS + 7) / 8) * 8;
	localparam int OUT_W       = ((3 * SAMPLE_BITS + CNT_W + 7) / 8) * 8;

	localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(10);

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;

	// control shared by all lanes, derived from the fill count and the window length
	typedef struct packed {
		logic [CNT_W-1:0]      fill;       // samples held before this item
		logic                  full;       // window at its length, oldest drops
		logic [IDX_W-1:0]      evict_age;  // age of the oldest sample when full
		logic [MAX_WINDOW-1:0] lo_oh;      // lower middle cell of sorted chain
		logic [MAX_WINDOW-1:0] hi_oh;      // upper middle cell of sorted chain
	} lane_ctrl_t;

endpackage

// ===== rtl/swm_lane.sv =====
// one axis lane: sorted cell chain with age tags, drops oldest and inserts new in the same update
// depends on swm_pkg
module swm_lane
	import swm_pkg::*;
(
	input  logic       clk,
	input  logic       ins,
	input  sample_t    sample,
	input  lane_ctrl_t ctrl,
	output sample_t    median
);

	sample_t          val_q [MAX_WINDOW];
	logic [IDX_W-1:0] age_q [MAX_WINDOW];

	logic [MAX_WINDOW-1:0] cle;
	logic [MAX_WINDOW-1:0] ev;
	logic [MAX_WINDOW-1:0] sh;
	logic [MAX_WINDOW-1:0] kle;
	logic [CNT_W-1:0]      kept;
	sample_t               kval [MAX_WINDOW];
	logic [IDX_W-1:0]      kage [MAX_WINDOW];
	logic                  kcle [MAX_WINDOW];
	sample_t               nval [MAX_WINDOW];
	logic [IDX_W-1:0]      nage [MAX_WINDOW];
	sample_t               lo;
	sample_t               hi;
	logic signed [SAMPLE_BITS:0] sum;

	// compare every cell against the new sample, find the cell to drop
	always_comb begin
		for (int j = 0; j < MAX_WINDOW; j++) begin
			cle[j] = (val_q[j] <= sample);
			ev[j]  = ctrl.full && (CNT_W'(j) < ctrl.fill) && (age_q[j] == ctrl.evict_age);
		end
		sh[0] = ev[0];
		for (int j = 1; j < MAX_WINDOW; j++) begin
			sh[j] = sh[j-1] | ev[j];
		end
		kept = ctrl.full ? (ctrl.fill - CNT_W'(1)) : ctrl.fill;
	end

	// chain with the dropped cell squeezed out
	genvar g;
	generate
		for (g = 0; g < MAX_WINDOW; g++) begin : g_kept
			if (g < MAX_WINDOW - 1) begin : g_mid
				assign kval[g] = sh[g] ? val_q[g+1] : val_q[g];
				assign kage[g] = sh[g] ? age_q[g+1] : age_q[g];
				assign kcle[g] = sh[g] ? cle[g+1] : cle[g];
			end else begin : g_end
				assign kval[g] = val_q[g];
				assign kage[g] = age_q[g];
				assign kcle[g] = cle[g];
			end
			assign kle[g] = (CNT_W'(g) < kept) && kcle[g];
		end
	endgenerate

	// insert the new sample after every kept cell not above it
	always_comb begin
		for (int i = 0; i < MAX_WINDOW; i++) begin
			if (kle[i]) begin
				nval[i] = kval[i];
				nage[i] = kage[i] + IDX_W'(1);
			end else if (i == 0) begin
				nval[i] = sample;
				nage[i] = '0;
			end else if (kle[i-1]) begin
				nval[i] = sample;
				nage[i] = '0;
			end else begin
				nval[i] = kval[i-1];
				nage[i] = kage[i-1] + IDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ins) begin
			for (int i = 0; i < MAX_WINDOW; i++) begin
				val_q[i] <= nval[i];
				age_q[i] <= nage[i];
			end
		end
	end

	// pick the middle pair and take the floored mean
	always_comb begin
		lo = '0;
		hi = '0;
		for (int j = 0; j < MAX_WINDOW; j++) begin
			lo = lo | (ctrl.lo_oh[j] ? val_q[j] : '0);
			hi = hi | (ctrl.hi_oh[j] ? val_q[j] : '0);
		end
		sum    = {lo[SAMPLE_BITS-1], lo} + {hi[SAMPLE_BITS-1], hi};
		median = sum[SAMPLE_BITS:1];
	end

endmodule

// ===== rtl/swm_merge.sv =====
// output register: gathers the three lane medians and the held count into one result item
// depends on swm_pkg
module swm_merge
	import swm_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  sample_t          med_x,
	input  sample_t          med_y,
	input  sample_t          med_z,
	input  logic [CNT_W-1:0] count,
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	output logic [OUT_W-1:0] m_axis_tdata
);

	logic             valid_q;
	sample_t          x_q;
	sample_t          y_q;
	sample_t          z_q;
	logic [CNT_W-1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			x_q   <= med_x;
			y_q   <= med_y;
			z_q   <= med_z;
			cnt_q <= count;
		end
	end

	assign m_axis_tvalid = valid_q;
	assign m_axis_tdata  = OUT_W'({cnt_q, z_q, y_q, x_q});

endmodule

// ===== rtl/sliding_window_median_xyz.sv =====
// top level of the three-axis sliding window median filter
// depends on swm_pkg, swm_lane and swm_merge
//
// channel  dir  handshake                    payload
// s_axis   in   s_axis_tvalid/s_axis_tready  sample_x, sample_y, sample_z
// m_axis   out  m_axis_tvalid/m_axis_tready  median_x, median_y, median_z, count_held
// cfg      in   cfg_we                       window_len
//
// one item per cycle while the output is not stalled: the sorted cell chain of
// each lane drops the oldest sample and inserts the new one in the accepting
// cycle, then the middle pair is picked and averaged into the output register
// reset (arst_n low) empties the windows and sets the window length to ten
// when the output stalls, one item waits in the update stage and input stalls
module sliding_window_median_xyz
	import swm_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	// cfg port: window_len
	input  logic             cfg_we,
	input  logic [LEN_W-1:0] cfg_wdata,
	// input item, from bit 0: sample_x[31:0], sample_y[63:32], sample_z[95:64]
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	input  logic [IN_W-1:0]  s_axis_tdata,
	// result item, from bit 0: median_x[31:0], median_y[63:32], median_z[95:64],
	// count_held[100:96], zero fill above
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	output logic [OUT_W-1:0] m_axis_tdata
);

	logic [LEN_W-1:0] len_q;
	logic [CNT_W-1:0] fill_q;
	logic             valid_s1;

	logic [CNT_W-1:0] eff_len;
	logic             accept;
	logic             adv_s1;
	logic [CNT_W-1:0] lo_cnt;
	logic [CNT_W-1:0] hi_cnt;
	logic [IDX_W-1:0] lo_idx;
	logic [IDX_W-1:0] hi_idx;
	lane_ctrl_t       ctrl;

	sample_t sample_x;
	sample_t sample_y;
	sample_t sample_z;
	sample_t med_x;
	sample_t med_y;
	sample_t med_z;

	assign sample_x = s_axis_tdata[SAMPLE_BITS-1:0];
	assign sample_y = s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
	assign sample_z = s_axis_tdata[3*SAMPLE_BITS-1:2*SAMPLE_BITS];

	// length zero acts as one, anything above the cell count acts as the cell count
	always_comb begin
		if (len_q == '0) begin
			eff_len = CNT_W'(1);
		end else if (32'(len_q) > MAX_WINDOW) begin
			eff_len = CNT_W'(MAX_WINDOW);
		end else begin
			eff_len = CNT_W'(len_q);
		end
	end

	// the update stage moves on when the output register is free or being drained
	assign adv_s1        = valid_s1 && (!m_axis_tvalid || m_axis_tready);
	assign s_axis_tready = !valid_s1 || adv_s1;
	assign accept        = s_axis_tvalid && s_axis_tready;

	// middle pair of the held samples; fill_q here already counts the newest item
	assign lo_cnt = (fill_q - CNT_W'(1)) >> 1;
	assign hi_cnt = fill_q >> 1;
	assign lo_idx = lo_cnt[IDX_W-1:0];
	assign hi_idx = hi_cnt[IDX_W-1:0];

	always_comb begin
		ctrl.fill      = fill_q;
		ctrl.full      = (fill_q == eff_len);
		ctrl.evict_age = IDX_W'(eff_len - CNT_W'(1));
		for (int j = 0; j < MAX_WINDOW; j++) begin
			ctrl.lo_oh[j] = (lo_idx == IDX_W'(j));
			ctrl.hi_oh[j] = (hi_idx == IDX_W'(j));
		end
	end

	// window length register; a write empties the windows
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= LEN_RESET;
		end else if (cfg_we) begin
			len_q <= cfg_wdata;
		end
	end

	// fill count grows until the window is full, then stays; a cfg write clears it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (cfg_we) begin
			fill_q <= '0;
		end else if (accept && !ctrl.full) begin
			fill_q <= fill_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	// one lane per axis, all driven by the same control
	swm_lane u_lane_x (
		.clk    (clk),
		.ins    (accept),
		.sample (sample_x),
		.ctrl   (ctrl),
		.median (med_x)
	);

	swm_lane u_lane_y (
		.clk    (clk),
		.ins    (accept),
		.sample (sample_y),
		.ctrl   (ctrl),
		.median (med_y)
	);

	swm_lane u_lane_z (
		.clk    (clk),
		.ins    (accept),
		.sample (sample_z),
		.ctrl   (ctrl),
		.median (med_z)
	);

	// merge the lane medians with the held count into the result item
	swm_merge u_merge (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (adv_s1),
		.med_x         (med_x),
		.med_y         (med_y),
		.med_z         (med_z),
		.count         (fill_q),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// self-checking testbench for sliding_window_median_xyz: directed table, then random phases
// depends on swm_pkg and the rtl of sliding_window_median_xyz
module tb
	import swm_pkg::*;
();

	localparam sample_t S_MAX      = 32'sh7fffffff;
	localparam sample_t S_MIN      = 32'sh80000000;
	localparam int      CYCLE_CAP  = 200000;
	localparam int      HOLD_LEN   = 60;
	localparam int      PHASE_SIZE = 100;

	// one result item as the predictor sees it
	typedef struct packed {
		sample_t          mx;
		sample_t          my;
		sample_t          mz;
		logic [CNT_W-1:0] held_cnt;
	} median_res_t;

	typedef enum logic [1:0] {
		ROW_CFG,   // write window_len, once the block has drained
		ROW_FIXED, // send item, expected result typed in the row
		ROW_PRED   // send item, expected result from the predictor
	} row_kind_t;

	typedef struct {
		row_kind_t        kind;
		logic [LEN_W-1:0] len_val;
		sample_t          sx;
		sample_t          sy;
		sample_t          sz;
		median_res_t      res;
	} stim_row_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             cfg_we = 1'b0;
	logic [LEN_W-1:0] cfg_wdata = '0;
	logic             s_axis_tvalid = 1'b0;
	logic             s_axis_tready;
	logic [IN_W-1:0]  s_axis_tdata = '0;
	logic             m_axis_tvalid;
	logic             m_axis_tready = 1'b0;
	logic [OUT_W-1:0] m_axis_tdata;

	// expected results, oldest first
	median_res_t median_q[$];
	int          errors = 0;
	int          cycles = 0;
	// no random idling on either side while set
	logic        quiet = 1'b0;
	// asks the result side for one long hold-off
	logic        hold_req = 1'b0;

	// predictor state: one ring per axis, fill level, oldest slot, raw register
	sample_t          ring [3][MAX_WINDOW];
	int unsigned      held = 0;
	int unsigned      head = 0;
	logic [LEN_W-1:0] len_reg = LEN_RESET;

	// directed part: extremes first, then wrap-around at length ten, then the
	// short, zero and oversized window lengths
	stim_row_t plan [28] = '{
		'{ROW_FIXED, '0, S_MAX, S_MIN, 32'sd0, '{S_MAX, S_MIN, 32'sd0, 5'd1}},
		// mean of the middle pair floors toward minus infinity
		'{ROW_FIXED, '0, S_MIN, S_MAX, -32'sd1, '{-32'sd1, -32'sd1, -32'sd1, 5'd2}},
		'{ROW_FIXED, '0, S_MAX, S_MIN, 32'sd1, '{S_MAX, S_MIN, 32'sd0, 5'd3}},
		'{ROW_PRED, '0, 32'sh55555555, 32'shaaaaaaaa, 32'sh00010000, '0},
		'{ROW_PRED, '0, 32'shaaaaaaaa, 32'sh55555555, 32'shffff0000, '0},
		'{ROW_PRED, '0, 32'sd1, -32'sd1, 32'sh7fff0000, '0},
		'{ROW_PRED, '0, -32'sd2, 32'sd2, 32'sh80010000, '0},
		'{ROW_PRED, '0, 32'sh12345678, 32'shedcba987, 32'sd3, '0},
		'{ROW_PRED, '0, 32'sd0, 32'sd0, 32'sd0, '0},
		'{ROW_PRED, '0, S_MAX, S_MAX, S_MAX, '0},
		// window full: oldest samples start to drop
		'{ROW_PRED, '0, S_MIN, S_MIN, S_MIN, '0},
		'{ROW_PRED, '0, 32'sd7, -32'sd7, 32'sd0, '0},
		'{ROW_CFG, 5'd1, '0, '0, '0, '0},
		'{ROW_FIXED, '0, 32'sd5, -32'sd5, 32'sd7, '{32'sd5, -32'sd5, 32'sd7, 5'd1}},
		'{ROW_FIXED, '0, S_MIN, S_MAX, 32'sd0, '{S_MIN, S_MAX, 32'sd0, 5'd1}},
		// zero length behaves as one
		'{ROW_CFG, 5'd0, '0, '0, '0, '0},
		'{ROW_FIXED, '0, -32'sd1, 32'sd0, S_MAX, '{-32'sd1, 32'sd0, S_MAX, 5'd1}},
		'{ROW_FIXED, '0, S_MAX, -32'sd1, S_MIN, '{S_MAX, -32'sd1, S_MIN, 5'd1}},
		'{ROW_CFG, 5'd2, '0, '0, '0, '0},
		'{ROW_FIXED, '0, S_MAX, S_MAX, S_MIN, '{S_MAX, S_MAX, S_MIN, 5'd1}},
		'{ROW_FIXED, '0, S_MAX, S_MIN, S_MIN, '{S_MAX, -32'sd1, S_MIN, 5'd2}},
		'{ROW_PRED, '0, 32'sd0, 32'sd0, 32'sd0, '0},
		// lengths above the maximum clamp to it
		'{ROW_CFG, 5'd31, '0, '0, '0, '0},
		'{ROW_PRED, '0, 32'sh00008000, -32'sh00008000, 32'sd1, '0},
		'{ROW_PRED, '0, -32'sd3, 32'sd3, -32'sd1, '0},
		'{ROW_CFG, 5'd17, '0, '0, '0, '0},
		'{ROW_PRED, '0, 32'sd2, 32'sd2, 32'sd2, '0},
		'{ROW_PRED, '0, -32'sd2, -32'sd2, -32'sd2, '0}
	};

	// window lengths of the random phases
	logic [LEN_W-1:0] phase_len [10] = '{5'd16, 5'd5, 5'd17, 5'd1, 5'd0, 5'd31, 5'd2,
		5'd10, 5'd7, 5'd16};

	sliding_window_median_xyz u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	always #1 clk = ~clk;

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_CAP) begin
			$display("%0t: timeout after %0d cycles", $time, cycles);
			$display("sliding_window_median_xyz test failed");
			$finish;
		end
	end

	// median of one axis over the samples held, middle pair averaged with floor
	function automatic sample_t axis_middle(int axis, int unsigned span);
		sample_t                  srt [MAX_WINDOW];
		sample_t                  v;
		int                       j;
		logic signed [SAMPLE_BITS:0] pair_sum;
		for (int i = 0; i < held; i++) begin
			v = ring[axis][(head + i) % span];
			j = i;
			while (j > 0 && srt[j-1] > v) begin
				srt[j] = srt[j-1];
				j--;
			end
			srt[j] = v;
		end
		pair_sum = {srt[(held - 1) / 2][SAMPLE_BITS-1], srt[(held - 1) / 2]}
			+ {srt[held / 2][SAMPLE_BITS-1], srt[held / 2]};
		return sample_t'(pair_sum >>> 1);
	endfunction

	// advance the predictor by one item and return the result it should give
	function automatic median_res_t predict_median(sample_t sx, sample_t sy, sample_t sz);
		int unsigned span;
		int unsigned slot;
		median_res_t r;
		span = (len_reg == 0) ? 1 : ((len_reg > MAX_WINDOW) ? MAX_WINDOW : len_reg);
		if (held < span) begin
			slot = (head + held) % span;
			held++;
		end else begin
			// full: overwrite the oldest and move the head on
			slot = head;
			head = (head + 1) % span;
		end
		ring[0][slot] = sx;
		ring[1][slot] = sy;
		ring[2][slot] = sz;
		r.mx = axis_middle(0, span);
		r.my = axis_middle(1, span);
		r.mz = axis_middle(2, span);
		r.held_cnt = CNT_W'(held);
		return r;
	endfunction

	function automatic void report_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			errors++;
			$display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
		end
	endfunction

	function automatic void check_median(logic [OUT_W-1:0] d);
		median_res_t want;
		if (median_q.size() == 0) begin
			errors++;
			$display("%0t: result with none expected, expected nothing, got %h", $time, d);
			return;
		end
		want = median_q.pop_front();
		report_field("median_x", want.mx, d[0 +: SAMPLE_BITS]);
		report_field("median_y", want.my, d[SAMPLE_BITS +: SAMPLE_BITS]);
		report_field("median_z", want.mz, d[2*SAMPLE_BITS +: SAMPLE_BITS]);
		report_field("count_held", 32'(want.held_cnt), 32'(d[3*SAMPLE_BITS +: CNT_W]));
	endfunction

	function automatic sample_t pick_sample();
		case ($urandom_range(9))
			0: return S_MAX;
			1: return S_MIN;
			// small values make ties and close neighbors
			2, 3: return sample_t'(int'($urandom_range(8)) - 4);
			default: return sample_t'($urandom());
		endcase
	endfunction

	// offer one item, wait for the handshake, then record the expectation
	task automatic send_sample(input sample_t sx, input sample_t sy, input sample_t sz,
		input logic typed, input median_res_t typed_res);
		median_res_t guess;
		if (!quiet && $urandom_range(99) < 24) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {sz, sy, sx};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		guess = predict_median(sx, sy, sz);
		median_q.insert(median_q.size(), typed ? typed_res : guess);
	endtask

	// stop offering and let every outstanding result come back
	task automatic settle_results();
		s_axis_tvalid <= 1'b0;
		while (median_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_window_len(input logic [LEN_W-1:0] val);
		settle_results();
		cfg_wdata <= val;
		cfg_we <= 1'b1;
		@(posedge clk);
		cfg_we <= 1'b0;
		// any write empties the windows
		len_reg = val;
		held = 0;
		head = 0;
	endtask

	// result side: check each accepted item, then pick the next ready
	initial begin : result_sink
		int hold_left;
		hold_left = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready) check_median(m_axis_tdata);
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else if (hold_req) begin
				// long hold-off so the block fills and stalls its input
				hold_req = 1'b0;
				hold_left = HOLD_LEN;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= !(!quiet && $urandom_range(99) < 24);
			end
		end
	end

	initial begin : stimulus
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			case (plan[i].kind)
				ROW_CFG: begin
					write_window_len(plan[i].len_val);
				end
				ROW_FIXED: begin
					send_sample(plan[i].sx, plan[i].sy, plan[i].sz, 1'b1, plan[i].res);
				end
				default: begin
					send_sample(plan[i].sx, plan[i].sy, plan[i].sz, 1'b0, '0);
				end
			endcase
		end

		// random phases, one window length each
		foreach (phase_len[p]) begin
			write_window_len(phase_len[p]);
			quiet = (p == 2);
			for (int k = 0; k < PHASE_SIZE; k++) begin
				if (p == 0 && k == 40) hold_req = 1'b1;
				// sender pause until the pipeline is empty
				if (p == 5 && k == 50) settle_results();
				send_sample(pick_sample(), pick_sample(), pick_sample(), 1'b0, '0);
			end
		end
		quiet = 1'b0;

		settle_results();
		repeat (8) @(posedge clk);
		if (errors == 0) begin
			$display("sliding_window_median_xyz test passed");
		end else begin
			$display("sliding_window_median_xyz test failed");
		end
		$finish;
	end

endmodule

// ===== sliding_window_median_xyz.f =====
rtl/swm_pkg.sv
rtl/swm_lane.sv
rtl/swm_merge.sv
rtl/sliding_window_median_xyz.sv
tb/tb.sv
